// ===== src/kbr_pkg.sv =====
// Shared types and constants for the multi-source keyboard report block.
package kbr_pkg;

  localparam int USAGE_W    = 8;
  localparam int USAGE_N    = 256;
  localparam int KEY_SLOTS  = 6;
  localparam int SLOT_CNT_W = 3;   // holds 0..KEY_SLOTS+1 (saturating)
  localparam int MOD_COUNT  = 8;
  localparam int MOD_IDX_W  = 3;
  localparam int SRC_W      = 5;
  localparam int ACT_W      = 3;

  localparam logic [USAGE_W-1:0] MOD_FIRST     = 8'd224;
  localparam logic [USAGE_W-1:0] MOD_LAST      = 8'd231;
  localparam logic [USAGE_W-1:0] ROLLOVER_CODE = 8'h01;
  localparam logic [USAGE_W-1:0] SCAN_FIRST    = 8'd1;
  localparam logic [USAGE_W-1:0] SCAN_LAST     = 8'd255;

  typedef logic [ACT_W-1:0] action_t;

  localparam action_t ACT_KEY     = 3'd0;
  localparam action_t ACT_MOD     = 3'd1;
  localparam action_t ACT_COMMIT  = 3'd2;
  localparam action_t ACT_REL_SRC = 3'd3;
  localparam action_t ACT_REL_ALL = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_KEY_WR,
    ST_SCAN,
    ST_SCAN_END,
    ST_REPORT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input transfer
    logic key_rd;      // read owner entry of latched usage
    logic key_wr;      // apply key event to read entry
    logic mod_upd;     // apply modifier event
    logic mod_rel;     // drop source from modifier owners
    logic clr_all;     // release all
    logic scan_start;  // reset scan address and slot collector
    logic scan_rd;     // issue one scan read
    logic rpt_load;    // load output register, clear dirty
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    action_t act;
    logic    src_ok;
    logic    usage_zero;
    logic    dirty;
    logic    scan_last;
    logic    out_free;
  } stat_t;

endpackage

// ===== src/kbr_ctrl.sv =====
// Controller state machine for the keyboard report block.
module kbr_ctrl
  import kbr_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_nxt = ST_IDLE;
        unique case (stat.act)
          ACT_KEY: begin
            if (stat.src_ok && !stat.usage_zero) begin
              cmd.key_rd = 1'b1;
              state_nxt  = ST_KEY_WR;
            end
          end
          ACT_MOD: begin
            cmd.mod_upd = 1'b1;
          end
          ACT_COMMIT: begin
            if (stat.dirty) begin
              cmd.scan_start = 1'b1;
              state_nxt      = ST_SCAN;
            end
          end
          ACT_REL_SRC: begin
            if (stat.src_ok) begin
              cmd.mod_rel    = 1'b1;
              cmd.scan_start = 1'b1;
              state_nxt      = ST_SCAN;
            end
          end
          ACT_REL_ALL: begin
            cmd.clr_all = 1'b1;
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      ST_KEY_WR: begin
        cmd.key_wr = 1'b1;
        state_nxt  = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        // last read data is consumed in this cycle
        state_nxt = (stat.act == ACT_COMMIT) ? ST_REPORT : ST_IDLE;
      end
      ST_REPORT: begin
        if (stat.out_free) begin
          cmd.rpt_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== src/kbr_datapath.sv =====
// Datapath: owner memory, modifier owners, scan pipeline and report register.
module kbr_datapath
  import kbr_pkg::*;
#(
  parameter int SOURCE_COUNT = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  action_t                           in_action,
  input  logic [SRC_W-1:0]                  in_source,
  input  logic [USAGE_W-1:0]                in_usage,
  input  logic                              in_pressed,
  input  cmd_t                              cmd,
  output stat_t                             stat,
  input  logic                              out_ready,
  output logic                              out_valid,
  output logic [USAGE_W-1:0]                out_mod,
  output logic [KEY_SLOTS-1:0][USAGE_W-1:0] out_slots
);

  typedef logic [SOURCE_COUNT-1:0] mask_t;

  // latched item
  action_t            act_r;
  logic [SRC_W-1:0]   src_r;
  logic [USAGE_W-1:0] usage_r;
  logic               pressed_r;

  // key owner memory with per-entry valid bits
  mask_t              mem [USAGE_N];
  logic [USAGE_N-1:0] vld_r;
  mask_t              rd_data_r;
  logic               rd_vld_r;
  logic [USAGE_W-1:0] rd_addr;

  logic               wr_en;
  logic [USAGE_W-1:0] wr_addr;
  mask_t              wr_data;

  // scan pipeline
  logic [USAGE_W-1:0] scan_r;
  logic               pend_r;
  logic [USAGE_W-1:0] paddr_r;

  // modifier state
  mask_t              own_r   [MOD_COUNT];
  mask_t              own_nxt [MOD_COUNT];
  logic [MOD_COUNT-1:0] mstate_r, mstate_nxt;
  logic               mod_dirty;
  logic               dirty_r, dirty_nxt;

  // slot collector
  logic [SLOT_CNT_W-1:0]             cnt_r;
  logic [KEY_SLOTS-1:0][USAGE_W-1:0] slot_r;

  // output register
  logic                              out_vld_r;
  logic [USAGE_W-1:0]                out_mod_r;
  logic [KEY_SLOTS-1:0][USAGE_W-1:0] out_slot_r;

  logic               src_ok;
  mask_t              sbit;
  mask_t              entry;
  mask_t              key_now;
  mask_t              rel_now;
  logic               mod_in_range;
  logic [MOD_IDX_W-1:0] midx;
  mask_t              mod_now;
  logic               rollover;

  assign src_ok = {1'b0, src_r} < (SRC_W + 1)'(SOURCE_COUNT);

  always_comb begin
    for (int i = 0; i < SOURCE_COUNT; i++) begin
      sbit[i] = src_ok && (src_r == SRC_W'(i));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r     <= in_action;
      src_r     <= in_source;
      usage_r   <= in_usage;
      pressed_r <= in_pressed;
    end
  end

  // owner entry as seen after the registered read
  assign entry   = rd_vld_r ? rd_data_r : '0;
  assign key_now = pressed_r ? (entry | sbit) : (entry & ~sbit);
  assign rel_now = entry & ~sbit;
  assign rd_addr = cmd.key_rd ? usage_r : scan_r;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = usage_r;
    wr_data = key_now;
    if (cmd.key_wr && (key_now != entry)) begin
      wr_en = 1'b1;
    end else if (pend_r && (act_r == ACT_REL_SRC) && (rel_now != entry)) begin
      wr_en   = 1'b1;
      wr_addr = paddr_r;
      wr_data = rel_now;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
    rd_vld_r  <= vld_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clr_all) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  // scan address and read pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.scan_rd;
    end
    paddr_r <= scan_r;
    if (cmd.scan_start) begin
      scan_r <= SCAN_FIRST;
    end else if (cmd.scan_rd) begin
      scan_r <= scan_r + 1'b1;
    end
  end

  // modifier owners
  assign mod_in_range = (usage_r >= MOD_FIRST) && (usage_r <= MOD_LAST);
  assign midx         = usage_r[MOD_IDX_W-1:0];
  assign mod_now      = pressed_r ? (own_r[midx] | sbit) : (own_r[midx] & ~sbit);

  always_comb begin
    own_nxt    = own_r;
    mstate_nxt = mstate_r;
    mod_dirty  = 1'b0;
    if (cmd.clr_all) begin
      for (int i = 0; i < MOD_COUNT; i++) begin
        own_nxt[i] = '0;
      end
      mstate_nxt = '0;
    end else if (cmd.mod_upd && src_ok && mod_in_range) begin
      own_nxt[midx]    = mod_now;
      mstate_nxt[midx] = |mod_now;
      mod_dirty        = (mstate_nxt[midx] != mstate_r[midx]);
    end else if (cmd.mod_rel) begin
      for (int i = 0; i < MOD_COUNT; i++) begin
        own_nxt[i] = own_r[i] & ~sbit;
        if (own_nxt[i] != own_r[i]) begin
          mod_dirty = 1'b1;
          if (own_nxt[i] == '0) begin
            mstate_nxt[i] = 1'b0;
          end
        end
      end
    end
  end

  always_comb begin
    dirty_nxt = dirty_r;
    if (cmd.clr_all) begin
      dirty_nxt = 1'b1;
    end else if (cmd.rpt_load) begin
      dirty_nxt = 1'b0;
    end else if (wr_en || mod_dirty) begin
      dirty_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MOD_COUNT; i++) begin
        own_r[i] <= '0;
      end
      mstate_r <= '0;
      dirty_r  <= 1'b0;
    end else begin
      own_r    <= own_nxt;
      mstate_r <= mstate_nxt;
      dirty_r  <= dirty_nxt;
    end
  end

  // collect first pressed usages in ascending order
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      cnt_r  <= '0;
      slot_r <= '0;
    end else if (pend_r && (act_r == ACT_COMMIT) && (entry != '0)) begin
      for (int i = 0; i < KEY_SLOTS; i++) begin
        if (cnt_r == SLOT_CNT_W'(i)) begin
          slot_r[i] <= paddr_r;
        end
      end
      if (cnt_r <= SLOT_CNT_W'(KEY_SLOTS)) begin
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign rollover = cnt_r > SLOT_CNT_W'(KEY_SLOTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (cmd.rpt_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rpt_load) begin
      out_mod_r <= mstate_r;
      for (int i = 0; i < KEY_SLOTS; i++) begin
        out_slot_r[i] <= rollover ? ROLLOVER_CODE : slot_r[i];
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_mod   = out_mod_r;
  assign out_slots = out_slot_r;

  assign stat.act        = act_r;
  assign stat.src_ok     = src_ok;
  assign stat.usage_zero = (usage_r == '0);
  assign stat.dirty      = dirty_r;
  assign stat.scan_last  = (scan_r == SCAN_LAST);
  assign stat.out_free   = !out_vld_r || out_ready;

endmodule

// ===== src/multi_source_keyboard_report.sv =====
// Top level of the multi-source keyboard report merger.
//
//  channel  dir  ports                            contents
//  in       in   in_tvalid/in_tready/in_tdata/    one event: key, modifier, commit,
//                in_tuser                         release source, release all
//  out      out  out_tvalid/out_tready/out_tdata  one 7-byte keyboard report
//
//  Steps: key event: accept, decode, read-modify-write; modifier, release-all and
//  ignored events: accept, decode; release-source and commit while dirty: accept,
//  decode, a walk over usages 1..255 through the single read port of the owner
//  memory, last data, and for the commit a load once the output register is free.
//  Input is taken only when the controller is idle; one transfer in flight.
//  Reset: synchronous, active low; owner memory entries are marked invalid at once
//  by per-entry valid bits, so no clearing pass follows reset.
//  Stalls: the report sits in an output register; events are taken while it waits
//  and only a further commit that finds the report dirty holds, after its scan,
//  until that report has been transferred.
module multi_source_keyboard_report
  import kbr_pkg::*;
#(
  parameter int SOURCE_COUNT = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [4:0] source, [12:5] usage, [13] pressed, [15:14] zero
  input  logic [2:0]  in_tuser,   // [2:0] action
  // result channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // [7:0] modifier_bits, [15:8] key_slot_0 ..
                                  // [55:48] key_slot_5
);

  cmd_t  cmd;
  stat_t stat;

  logic [USAGE_W-1:0]                out_mod;
  logic [KEY_SLOTS-1:0][USAGE_W-1:0] out_slots;

  kbr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kbr_datapath #(
    .SOURCE_COUNT (SOURCE_COUNT)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_action  (in_tuser),
    .in_source  (in_tdata[4:0]),
    .in_usage   (in_tdata[12:5]),
    .in_pressed (in_tdata[13]),
    .cmd        (cmd),
    .stat       (stat),
    .out_ready  (out_tready),
    .out_valid  (out_tvalid),
    .out_mod    (out_mod),
    .out_slots  (out_slots)
  );

  // slot 0 sits right above the modifier byte
  assign out_tdata = {out_slots, out_mod};

endmodule

// ===== src/kbr_checker.sv =====
// Port-level checker for the keyboard report block, with its bind.
module kbr_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata
);

  // no report right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("report valid after reset");

  // one event in flight: ready drops after every input transfer
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken twice in a row");

  // a report needs a scan, never appears the cycle after an input transfer
  a_no_instant_rpt: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !out_tvalid |=> !out_tvalid)
    else $error("report without scan");

  // stalled report holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled report changed");

endmodule

bind multi_source_keyboard_report kbr_checker u_kbr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ===== dv/tb_multi_source_keyboard_report.sv =====
// Self-checking testbench: keyboard report merger vs. in-bench merge predictor.
`timescale 1ns / 1ps

module tb_multi_source_keyboard_report;
  import kbr_pkg::*;

  localparam int SRC_COUNT  = 8;
  localparam int CLK_PERIOD = 10;
  localparam int RAND_ITEMS = 1260;  // effective (not ignored) random transfers
  localparam int TAIL_ITEMS = 150;   // last stretch runs with no idling on either side
  localparam int LONG_HOLD  = 700;   // receiver hold-off, well over one usage scan
  localparam int SETTLE     = 400;   // cycles after the last report: one scan plus margin
  localparam int DRAIN_MAX  = 100000;
  localparam int MAX_PRINT  = 40;
  localparam int DIR_ROWS   = 28;

  // Action codes the block does not define; they must do nothing.
  localparam action_t ACT_RSVD     = 3'd5;
  localparam action_t ACT_RSVD_TOP = 3'd7;

  // Boot report as it sits on out_tdata: modifier byte low, slot 0 next, slot 5 on top.
  typedef struct packed {
    logic [KEY_SLOTS-1:0][USAGE_W-1:0] slots;
    logic [USAGE_W-1:0]                mod_bits;
  } kb_report_t;

  // One directed event; typed rows carry the report written out by hand.
  typedef struct packed {
    action_t            act;
    logic [SRC_W-1:0]   src;
    logic [USAGE_W-1:0] usage;
    logic               pressed;
    logic               typed;
    kb_report_t         report;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;
  logic [2:0]  in_tuser = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [55:0] out_tdata;

  always #(CLK_PERIOD / 2) clk = ~clk;

  multi_source_keyboard_report #(
    .SOURCE_COUNT(SRC_COUNT)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // ---------------------------------------------------------------------------
  // Merge predictor state: owner masks per usage and per modifier, merged
  // modifier byte and the report-dirty mark.
  // ---------------------------------------------------------------------------
  logic [SRC_COUNT-1:0] key_owner [USAGE_N];
  logic [SRC_COUNT-1:0] mod_owner [MOD_COUNT];
  logic [USAGE_W-1:0]   mod_held;
  bit                   report_dirty;

  kb_report_t report_q [$];   // reports still owed by the block, oldest first
  int         err_count = 0;
  int         rpt_seen  = 0;

  // Sender/receiver controls; the receiver ones are shared between processes.
  bit src_idle_en  = 1'b0;
  bit sink_idle_en = 1'b0;
  bit sink_hold_req = 1'b0;

  task automatic flag_mismatch(input string what);
    if (err_count < MAX_PRINT) $display("[%0t] MISMATCH: %s", $time, what);
    err_count++;
  endtask

  task automatic clear_merge_state();
    for (int u = 0; u < USAGE_N; u++) key_owner[u] = '0;
    for (int m = 0; m < MOD_COUNT; m++) mod_owner[m] = '0;
    mod_held = '0;
  endtask

  // Apply one accepted event to the predictor; emits is set when the event
  // is a commit that finds the report dirty.
  task automatic merge_event(input action_t act, input logic [SRC_W-1:0] src,
                             input logic [USAGE_W-1:0] usage, input logic pressed,
                             output bit emits, output kb_report_t rpt);
    logic [SRC_COUNT-1:0] sbit;
    logic [SRC_COUNT-1:0] nxt;
    logic [MOD_IDX_W-1:0] midx;
    logic [USAGE_W-1:0]   merged;
    int                   held;
    emits = 1'b0;
    rpt   = '0;
    sbit  = '0;
    held  = 0;
    if (src < SRC_COUNT) sbit = SRC_COUNT'(1) << src;
    case (act)
      ACT_KEY: begin
        if (sbit != '0 && usage != '0) begin
          nxt = pressed ? (key_owner[usage] | sbit) : (key_owner[usage] & ~sbit);
          if (nxt != key_owner[usage]) begin
            key_owner[usage] = nxt;
            report_dirty = 1'b1;
          end
        end
      end
      ACT_MOD: begin
        if (sbit != '0 && usage >= MOD_FIRST && usage <= MOD_LAST) begin
          midx = MOD_IDX_W'(usage - MOD_FIRST);
          nxt  = pressed ? (mod_owner[midx] | sbit) : (mod_owner[midx] & ~sbit);
          if (nxt != mod_owner[midx]) begin
            mod_owner[midx] = nxt;
            merged = mod_held;
            merged[midx] = (nxt != '0);
            // dirty only when the merged byte moves, not on owner changes alone
            if (merged != mod_held) begin
              mod_held = merged;
              report_dirty = 1'b1;
            end
          end
        end
      end
      ACT_COMMIT: begin
        if (report_dirty) begin
          rpt.mod_bits = mod_held;
          for (int u = 1; u < USAGE_N; u++) begin
            if (key_owner[u] != '0) begin
              if (held < KEY_SLOTS) rpt.slots[held] = USAGE_W'(u);
              held++;
            end
          end
          if (held > KEY_SLOTS)
            for (int s = 0; s < KEY_SLOTS; s++) rpt.slots[s] = ROLLOVER_CODE;
          report_dirty = 1'b0;
          emits = 1'b1;
        end
      end
      ACT_REL_SRC: begin
        if (sbit != '0) begin
          for (int u = 1; u < USAGE_N; u++) begin
            nxt = key_owner[u] & ~sbit;
            if (nxt != key_owner[u]) begin
              key_owner[u] = nxt;
              report_dirty = 1'b1;
            end
          end
          // any cleared owner bit marks dirty, even if the merged byte holds
          for (int m = 0; m < MOD_COUNT; m++) begin
            nxt = mod_owner[m] & ~sbit;
            if (nxt != mod_owner[m]) begin
              mod_owner[m] = nxt;
              if (nxt == '0) mod_held[m] = 1'b0;
              report_dirty = 1'b1;
            end
          end
        end
      end
      ACT_REL_ALL: begin
        clear_merge_state();
        report_dirty = 1'b1;
      end
      default: ;  // reserved codes: no effect
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input side. Called at a rising edge; leaves at the edge that completed
  // the transfer, with in_tvalid still high so a back-to-back transfer
  // needs only one assignment.
  // ---------------------------------------------------------------------------
  task automatic send_event(input action_t act, input logic [SRC_W-1:0] src,
                            input logic [USAGE_W-1:0] usage, input logic pressed,
                            input bit typed, input kb_report_t typed_rpt);
    bit         emits;
    kb_report_t rpt;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {2'b00, pressed, usage, src};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    merge_event(act, src, usage, pressed, emits, rpt);
    if (typed) report_q.push_back(typed_rpt);
    else if (emits) report_q.push_back(rpt);
  endtask

  task automatic src_gap(input int cycles);
    in_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Sender stops until every owed report has been transferred.
  task automatic drain_pause();
    in_tvalid <= 1'b0;
    while (report_q.size() != 0) @(posedge clk);
    repeat ($urandom_range(1, 18)) @(posedge clk);
  endtask

  // Random event: mostly well-formed traffic over a small usage pool so that
  // key counts swing across the rollover limit; the rest is ignored noise.
  task automatic gen_event(output action_t act, output logic [SRC_W-1:0] src,
                           output logic [USAGE_W-1:0] usage, output logic pressed,
                           output bit noise);
    int pick;
    pick    = $urandom_range(0, 99);
    src     = ($urandom_range(0, 9) != 0) ? SRC_W'($urandom_range(0, SRC_COUNT - 1))
                                          : SRC_W'($urandom_range(SRC_COUNT, 31));
    usage   = USAGE_W'($urandom_range(0, 255));
    pressed = ($urandom_range(0, 99) < 50);
    noise   = 1'b0;
    if (pick < 44) begin
      act = ACT_KEY;
      pick = $urandom_range(0, 99);
      if (pick < 65) usage = USAGE_W'($urandom_range(4, 13));
      else if (pick < 75) usage = USAGE_W'($urandom_range(MOD_FIRST, MOD_LAST));
      noise = (src >= SRC_COUNT) || (usage == '0);
    end else if (pick < 62) begin
      act = ACT_MOD;
      if ($urandom_range(0, 4) != 0) usage = USAGE_W'($urandom_range(MOD_FIRST, MOD_LAST));
      noise = (src >= SRC_COUNT) || (usage < MOD_FIRST) || (usage > MOD_LAST);
    end else if (pick < 84) begin
      act = ACT_COMMIT;
    end else if (pick < 91) begin
      act = ACT_REL_SRC;
      noise = (src >= SRC_COUNT);
    end else if (pick < 93) begin
      act = ACT_REL_ALL;
    end else begin
      act = action_t'($urandom_range(ACT_RSVD, ACT_RSVD_TOP));
      noise = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random ready bursts, plus one long hold-off on request so
  // the report register stays full and a second commit backs up the input.
  // ---------------------------------------------------------------------------
  initial begin : sink
    int hold;
    while (!rst_n) @(posedge clk);
    forever begin
      if (sink_hold_req) begin
        sink_hold_req = 1'b0;
        out_tready <= 1'b0;
        for (hold = 0; hold < LONG_HOLD; hold++) @(posedge clk);
      end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Every report transfer is checked field by field against the oldest owed one.
  always @(posedge clk) begin : report_check
    kb_report_t got;
    kb_report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = kb_report_t'(out_tdata);
      if (report_q.size() == 0) begin
        flag_mismatch($sformatf("report %0d not expected: %h", rpt_seen, out_tdata));
      end else begin
        want = report_q.pop_front();
        if (got.mod_bits !== want.mod_bits)
          flag_mismatch($sformatf("report %0d modifier_bits got %h want %h",
                                  rpt_seen, got.mod_bits, want.mod_bits));
        for (int s = 0; s < KEY_SLOTS; s++)
          if (got.slots[s] !== want.slots[s])
            flag_mismatch($sformatf("report %0d key_slot_%0d got %h want %h",
                                    rpt_seen, s, got.slots[s], want.slots[s]));
      end
      rpt_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Directed table. Typed rows: mixed sources with a modifier used as a key,
  // then a 7-key rollover, then the all-clear report after release-all.
  // ---------------------------------------------------------------------------
  stim_row_t dir_tbl [DIR_ROWS] = '{
    '{ACT_COMMIT,  5'd0,  8'd0,   1'b0, 1'b0, 56'h0},            // clean after reset
    '{ACT_KEY,     5'd0,  8'd4,   1'b1, 1'b0, 56'h0},
    '{ACT_KEY,     5'd7,  8'd255, 1'b1, 1'b0, 56'h0},            // top source, top usage
    '{ACT_KEY,     5'd8,  8'd5,   1'b1, 1'b0, 56'h0},            // first invalid source
    '{ACT_KEY,     5'd31, 8'd6,   1'b1, 1'b0, 56'h0},            // last invalid source
    '{ACT_KEY,     5'd0,  8'd0,   1'b1, 1'b0, 56'h0},            // usage zero ignored
    '{ACT_MOD,     5'd0,  8'd224, 1'b1, 1'b0, 56'h0},
    '{ACT_MOD,     5'd1,  8'd231, 1'b1, 1'b0, 56'h0},
    '{ACT_MOD,     5'd2,  8'd223, 1'b1, 1'b0, 56'h0},            // just below modifiers
    '{ACT_MOD,     5'd2,  8'd232, 1'b1, 1'b0, 56'h0},            // just above modifiers
    '{ACT_KEY,     5'd2,  8'd224, 1'b1, 1'b0, 56'h0},            // modifier usage as key
    '{ACT_COMMIT,  5'd0,  8'd0,   1'b0, 1'b1, 56'h000000FFE00481},
    '{ACT_KEY,     5'd0,  8'd4,   1'b1, 1'b0, 56'h0},            // already held
    '{ACT_MOD,     5'd3,  8'd224, 1'b1, 1'b0, 56'h0},            // merged byte unchanged
    '{ACT_COMMIT,  5'd0,  8'd0,   1'b0, 1'b0, 56'h0},            // still clean
    '{ACT_KEY,     5'd1,  8'd10,  1'b1, 1'b0, 56'h0},
    '{ACT_KEY,     5'd1,  8'd11,  1'b1, 1'b0, 56'h0},
    '{ACT_KEY,     5'd1,  8'd12,  1'b1, 1'b0, 56'h0},
    '{ACT_KEY,     5'd1,  8'd13,  1'b1, 1'b0, 56'h0},
    '{ACT_COMMIT,  5'd0,  8'd0,   1'b0, 1'b1, 56'h01010101010181},
    '{ACT_KEY,     5'd7,  8'd255, 1'b0, 1'b0, 56'h0},
    '{ACT_MOD,     5'd1,  8'd231, 1'b0, 1'b0, 56'h0},
    '{ACT_REL_SRC, 5'd9,  8'd0,   1'b0, 1'b0, 56'h0},            // invalid source
    '{ACT_REL_SRC, 5'd0,  8'd0,   1'b0, 1'b0, 56'h0},            // shared modifier stays
    '{ACT_RSVD,    5'd3,  8'd20,  1'b1, 1'b0, 56'h0},
    '{ACT_COMMIT,  5'd0,  8'd0,   1'b0, 1'b0, 56'h0},
    '{ACT_REL_ALL, 5'd0,  8'd0,   1'b0, 1'b0, 56'h0},
    '{ACT_COMMIT,  5'd0,  8'd0,   1'b0, 1'b1, 56'h0}
  };

  initial begin : stimulus
    action_t            act;
    logic [SRC_W-1:0]   src;
    logic [USAGE_W-1:0] usage;
    logic               pressed;
    bit                 noise;
    int                 effective;
    int                 waited;

    clear_merge_state();
    report_dirty = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, no idling on either side.
    foreach (dir_tbl[i])
      send_event(dir_tbl[i].act, dir_tbl[i].src, dir_tbl[i].usage, dir_tbl[i].pressed,
                 dir_tbl[i].typed, dir_tbl[i].report);

    // Back-pressure: the receiver holds off while commits keep coming, so the
    // second report has nowhere to go and the input stalls.
    sink_hold_req = 1'b1;
    send_event(ACT_REL_ALL, '0, '0, 1'b0, 1'b0, '0);
    send_event(ACT_COMMIT, '0, '0, 1'b0, 1'b0, '0);
    for (int k = 0; k < 2; k++) begin
      send_event(ACT_KEY, SRC_W'($urandom_range(0, SRC_COUNT - 1)),
                 USAGE_W'($urandom_range(4, 100)), 1'b1, 1'b0, '0);
      send_event(ACT_COMMIT, '0, '0, 1'b0, 1'b0, '0);
    end
    drain_pause();

    // Random part.
    effective = 0;
    while (effective < RAND_ITEMS) begin
      if (effective % 64 == 0) begin
        src_idle_en  = ($urandom_range(0, 3) != 0);
        sink_idle_en = ($urandom_range(0, 3) != 0);
      end
      if (effective >= RAND_ITEMS - TAIL_ITEMS) begin
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
      end
      gen_event(act, src, usage, pressed, noise);
      if (src_idle_en && $urandom_range(0, 99) == 0) drain_pause();
      else if (src_idle_en && $urandom_range(0, 4) == 0) src_gap($urandom_range(1, 18));
      send_event(act, src, usage, pressed, 1'b0, '0);
      if (!noise) effective++;
    end
    in_tvalid <= 1'b0;

    // Let every owed report arrive, then one scan's worth of quiet to catch
    // anything extra the block might still send.
    waited = 0;
    while (report_q.size() != 0 && waited < DRAIN_MAX) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (report_q.size() != 0)
      flag_mismatch($sformatf("%0d reports never arrived", report_q.size()));

    if (err_count == 0) begin
      $display("** multi_source_keyboard_report: PASSED **");
    end else begin
      $display("** multi_source_keyboard_report: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin : watchdog
    #20ms;
    $display("[%0t] timeout", $time);
    $display("** multi_source_keyboard_report: FAILED **");
    $finish;
  end

endmodule
